FILE: sv/oaht_pkg.sv
// package for the open addressing hash table core
// types, function codes, status codes and defaults; no dependencies
package oaht_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 64;
    localparam int DEFAULT_KEY_WIDTH   = 32;
    localparam int DEFAULT_VALUE_WIDTH = 32;
    localparam logic [6:0] DEFAULT_TABLE_SIZE = 7'd15;

    localparam logic [1:0] FUNC_SEARCH = 2'd0;
    localparam logic [1:0] FUNC_INSERT = 2'd1;
    localparam logic [1:0] FUNC_ASSIGN = 2'd2;
    localparam logic [1:0] FUNC_ERASE  = 2'd3;

    localparam logic [1:0] STATUS_DONE      = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_PRESENT   = 2'd2;
    localparam logic [1:0] STATUS_FULL      = 2'd3;

    localparam logic [1:0] SLOT_EMPTY    = 2'd0;
    localparam logic [1:0] SLOT_OCCUPIED = 2'd1;
    localparam logic [1:0] SLOT_TOMB     = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] key;
        logic [31:0] value;
    } cmd_t;

    typedef struct packed {
        logic        found;
        logic [31:0] value_out;
        logic [1:0]  status;
        logic [6:0]  occupied_count;
    } result_t;

endpackage

FILE: sv/oaht_ram.sv
// generic single-port-write, single-read ram with registered read data
// no dependencies
module oaht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/open_addressing_hash_table_core.sv
// top level of the open addressing hash table core
// uses oaht_pkg and oaht_ram (state, key and value memories)
//
//  channel   signals                      direction  handshake
//  command   start, busy, cmd             in         start && !busy
//  result    done, result                 out        done strobe, one cycle
//  config    table_size_we, table_size_wr in         table_size_we
//
// a transaction computes the home index by restoring shift-subtract (one key
// bit a cycle), then probes, each a memory read then a compare, up to n probes
// with n the table size clamped to 1..TABLE_DEPTH, then does the write-back; done
// comes in the cycle after the write-back, when busy is already low. after
// reset a clearing pass empties every entry of the state memory, busy
// stays high meanwhile. the receiver cannot stall.
module open_addressing_hash_table_core #(
    parameter int TABLE_DEPTH = oaht_pkg::DEFAULT_TABLE_DEPTH,
    parameter int KEY_WIDTH   = oaht_pkg::DEFAULT_KEY_WIDTH,
    parameter int VALUE_WIDTH = oaht_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  oaht_pkg::cmd_t   cmd,
    output logic             done,
    output oaht_pkg::result_t result,
    input  logic             table_size_we,
    input  logic [6:0]       table_size_wr
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int NW = $clog2(TABLE_DEPTH + 1);
    localparam int KW = KEY_WIDTH;
    localparam int CW = $clog2(KW + 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MOD   = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_WRITE = 3'd5;

    logic [2:0]             state_reg, state_next;
    logic [6:0]             size_reg;
    logic [NW-1:0]          n_reg;
    logic [1:0]             func_reg;
    logic [KW-1:0]          key_reg;
    logic [VALUE_WIDTH-1:0] val_reg;
    logic [KW-1:0]          quot_reg;
    logic [NW:0]            rem_reg;
    logic [CW-1:0]          bit_reg;
    logic [AW-1:0]          idx_reg;
    logic [NW-1:0]          j_reg;
    logic [AW-1:0]          clr_reg;
    logic [NW-1:0]          occ_reg;
    logic                   hit_reg, hole_reg;
    logic [VALUE_WIDTH-1:0] hitval_reg;
    logic                   found_reg;
    logic [31:0]            value_out_reg;
    logic [1:0]             status_reg;

    // memory ports
    logic                   st_we, kv_we;
    logic [AW-1:0]          st_waddr;
    logic [1:0]             st_wdata, st_rdata;
    logic [KW-1:0]          key_rdata;
    logic [VALUE_WIDTH-1:0] val_rdata;

    // size in use, clamped to 1..TABLE_DEPTH
    logic [NW-1:0] n_eff;
    always_comb
    begin
        if (size_reg == 7'd0)
            n_eff = NW'(1);
        else if (32'(size_reg) > 32'(TABLE_DEPTH))
            n_eff = NW'(TABLE_DEPTH);
        else
            n_eff = NW'(size_reg);
    end

    oaht_ram #(.WIDTH(2), .DEPTH(TABLE_DEPTH)) u_state_ram (
        .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
        .raddr(idx_reg), .rdata(st_rdata)
    );
    oaht_ram #(.WIDTH(KW), .DEPTH(TABLE_DEPTH)) u_key_ram (
        .clk(clk), .we(kv_we), .waddr(idx_reg), .wdata(key_reg),
        .raddr(idx_reg), .rdata(key_rdata)
    );
    oaht_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(TABLE_DEPTH)) u_value_ram (
        .clk(clk), .we(kv_we), .waddr(idx_reg), .wdata(val_reg),
        .raddr(idx_reg), .rdata(val_rdata)
    );

    // restoring division step, one key bit a cycle
    logic [NW:0] rem_shift;
    assign rem_shift = {rem_reg[NW-1:0], quot_reg[KW-1]};

    // next probe index: (idx + j + 1) mod n, idx and j both below n
    logic [NW:0] step_sum;
    assign step_sum = (NW+1)'(idx_reg) + (NW+1)'(j_reg);

    logic occ_match;
    assign occ_match = (st_rdata == oaht_pkg::SLOT_OCCUPIED) && (key_rdata == key_reg);

    logic accept;
    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        st_we      = 1'b0;
        kv_we      = 1'b0;
        st_waddr   = idx_reg;
        st_wdata   = oaht_pkg::SLOT_EMPTY;
        case (state_reg)
            S_CLEAR:
            begin
                st_we    = 1'b1;
                st_waddr = clr_reg;
                if (32'(clr_reg) == TABLE_DEPTH - 1)
                    state_next = S_IDLE;
            end
            S_IDLE:  if (accept) state_next = S_MOD;
            S_MOD:   if (bit_reg == CW'(1)) state_next = S_READ;
            S_READ:  state_next = S_CHECK;
            S_CHECK:
            begin
                if (st_rdata == oaht_pkg::SLOT_EMPTY || occ_match
                    || j_reg + NW'(1) == n_reg)
                    state_next = S_WRITE;
                else
                    state_next = S_READ;
            end
            S_WRITE:
            begin
                state_next = S_IDLE;
                if (hit_reg && func_reg == oaht_pkg::FUNC_ERASE)
                begin
                    st_we    = 1'b1;
                    st_wdata = oaht_pkg::SLOT_TOMB;
                end
                else if (!hit_reg && hole_reg && (func_reg == oaht_pkg::FUNC_INSERT
                         || func_reg == oaht_pkg::FUNC_ASSIGN))
                begin
                    st_we    = 1'b1;
                    st_wdata = oaht_pkg::SLOT_OCCUPIED;
                    kv_we    = 1'b1;
                end
                else if (hit_reg && func_reg == oaht_pkg::FUNC_ASSIGN)
                begin
                    // key still goes back in unchanged
                    kv_we = 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            size_reg  <= oaht_pkg::DEFAULT_TABLE_SIZE;
            clr_reg   <= '0;
            occ_reg   <= '0;
            done      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done      <= 1'b0;
            if (table_size_we)
                size_reg <= table_size_wr;
            if (state_reg == S_CLEAR)
                clr_reg <= clr_reg + AW'(1);
            if (state_reg == S_WRITE)
            begin
                done <= 1'b1;
                if (st_we && st_wdata == oaht_pkg::SLOT_OCCUPIED)
                    occ_reg <= occ_reg + NW'(1);
                else if (st_we && occ_reg != '0)
                    occ_reg <= occ_reg - NW'(1);
            end
        end
    end

    // payload and walk registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                func_reg <= cmd.func;
                key_reg  <= KW'(cmd.key);
                val_reg  <= VALUE_WIDTH'(cmd.value);
                quot_reg <= KW'(cmd.key);
                rem_reg  <= '0;
                bit_reg  <= CW'(KW);
                n_reg    <= n_eff;
                j_reg    <= '0;
                hit_reg  <= 1'b0;
                hole_reg <= 1'b0;
            end
            S_MOD:
            begin
                quot_reg <= quot_reg << 1;
                bit_reg  <= bit_reg - CW'(1);
                if (rem_shift >= (NW+1)'(n_reg))
                    rem_reg <= rem_shift - (NW+1)'(n_reg);
                else
                    rem_reg <= rem_shift;
                if (bit_reg == CW'(1))
                begin
                    if (rem_shift >= (NW+1)'(n_reg))
                        idx_reg <= AW'(rem_shift - (NW+1)'(n_reg));
                    else
                        idx_reg <= AW'(rem_shift);
                end
            end
            S_CHECK:
            begin
                hitval_reg <= val_rdata;
                if (st_rdata == oaht_pkg::SLOT_EMPTY)
                    hole_reg <= 1'b1;
                else if (occ_match)
                    hit_reg <= 1'b1;
                else if (j_reg + NW'(1) != n_reg)
                begin
                    j_reg <= j_reg + NW'(1);
                    if (step_sum + (NW+1)'(1) >= (NW+1)'(n_reg))
                        idx_reg <= AW'(step_sum + (NW+1)'(1) - (NW+1)'(n_reg));
                    else
                        idx_reg <= AW'(step_sum + (NW+1)'(1));
                end
            end
            S_WRITE:
            begin
                found_reg     <= hit_reg;
                value_out_reg <= hit_reg ? 32'(hitval_reg) : 32'd0;
                if (func_reg == oaht_pkg::FUNC_SEARCH || func_reg == oaht_pkg::FUNC_ERASE)
                    status_reg <= hit_reg ? oaht_pkg::STATUS_DONE
                                          : oaht_pkg::STATUS_NOT_FOUND;
                else if (hit_reg)
                    status_reg <= (func_reg == oaht_pkg::FUNC_ASSIGN)
                                  ? oaht_pkg::STATUS_DONE : oaht_pkg::STATUS_PRESENT;
                else
                    status_reg <= hole_reg ? oaht_pkg::STATUS_DONE
                                           : oaht_pkg::STATUS_FULL;
            end
            default: ;
        endcase
    end

    // occupancy shown after its update
    assign result = {found_reg, value_out_reg, status_reg, 7'(occ_reg)};

    a_done_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held two cycles");
    a_done_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg) == S_WRITE) else $error("done without write-back");
    a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CHECK |-> j_reg < n_reg) else $error("probe walk overran");
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |-> NW'(idx_reg) < n_reg) else $error("index out of range");

endmodule
